### design/deq_pkg.sv
// Shared definitions for the circular deque: request codes, status codes
// and the control record that travels from the front end to the back end.
// No dependencies.
package deq_pkg;

   localparam logic [2:0] FUNC_PUSH_REAR  = 3'd0;
   localparam logic [2:0] FUNC_POP_REAR   = 3'd1;
   localparam logic [2:0] FUNC_PEEK_REAR  = 3'd2;
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd3;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd4;
   localparam logic [2:0] FUNC_PEEK_FRONT = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int unsigned WORD_W = 32;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [1:0] status;
      logic       now_empty;
      logic       now_full;
   } deq_ctl_type;

endpackage

### design/circular_deque.sv
// Circular deque of signed 32-bit words, up to DEPTH-1 entries.
// Depends on deq_pkg, deq_front, deq_fifo and deq_back.
// A transferred request passes the command queue, then the RAM read and back-end result registers.
// One request per cycle when not busy; the ring RAM's single port serves one access each cycle.
// busy rises only if the two-entry command queue fills, which a non-stalling result side avoids.
// Synchronous active-high reset empties the deque and the queue; ring contents are not cleared.
module circular_deque #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_func,
   input  logic signed [31:0]       req_push_value,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_read_value,
   output logic [1:0]               rsp_status,
   output logic                     rsp_now_empty,
   output logic                     rsp_now_full,
   output logic [$clog2(DEPTH)-1:0] rsp_fill_count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CTL_W = $bits(deq_pkg::deq_ctl_type);
   localparam int CMD_W = CTL_W + PTR_W + deq_pkg::WORD_W + PTR_W;

   logic                       accept;
   deq_pkg::deq_ctl_type       fr_ctl, bk_ctl;
   logic [PTR_W-1:0]           fr_addr, bk_addr;
   logic [deq_pkg::WORD_W-1:0] fr_wdata, bk_wdata;
   logic [PTR_W-1:0]           fr_count, bk_count;
   logic [CMD_W-1:0]           q_pop_data;
   logic                       q_not_empty, q_full, q_pop;

   assign busy   = q_full;
   assign accept = start && !busy;

   deq_front #(.DEPTH(DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .push_value(req_push_value),
      .ctl       (fr_ctl),
      .addr      (fr_addr),
      .wdata     (fr_wdata),
      .count     (fr_count)
   );

   deq_fifo #(.WIDTH(CMD_W)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_data({fr_ctl, fr_addr, fr_wdata, fr_count}),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .not_empty(q_not_empty),
      .full     (q_full)
   );

   assign {bk_ctl, bk_addr, bk_wdata, bk_count} = q_pop_data;

   deq_back #(.DEPTH(DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_not_empty),
      .cmd_ctl       (bk_ctl),
      .cmd_addr      (bk_addr),
      .cmd_wdata     (bk_wdata),
      .cmd_count     (bk_count),
      .cmd_pop       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_now_empty (rsp_now_empty),
      .rsp_now_full  (rsp_now_full),
      .rsp_fill_count(rsp_fill_count)
   );

endmodule

### design/deq_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/deq_front.sv
// Front end of the deque: holds the head and tail pointers, classifies each
// request, and emits one ring access with the resulting flags and count.
// Depends on deq_pkg.
module deq_front #(
   parameter int DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [2:0]                func,
   input  logic signed [31:0]        push_value,
   output deq_pkg::deq_ctl_type      ctl,
   output logic [$clog2(DEPTH)-1:0]  addr,
   output logic [deq_pkg::WORD_W-1:0] wdata,
   output logic [$clog2(DEPTH)-1:0]  count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             empty, full;
   logic [PTR_W:0]   cnt_wide;

   function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
      return (p == LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST : p - PTR_W'(1);
   endfunction

   assign empty = (head_ff == tail_ff);
   assign full  = (step_up(tail_ff) == head_ff);
   assign wdata = push_value;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      addr       = tail_ff;
      ctl.wr_en  = 1'b0;
      ctl.rd_en  = 1'b0;
      ctl.status = deq_pkg::ST_OK;
      unique case (func)
         deq_pkg::FUNC_PUSH_REAR: begin
            if (full) begin
               ctl.status = deq_pkg::ST_FULL;
            end else begin
               tail_in   = step_up(tail_ff);
               addr      = step_up(tail_ff);
               ctl.wr_en = 1'b1;
            end
         end
         deq_pkg::FUNC_POP_REAR: begin
            if (empty) begin
               ctl.status = deq_pkg::ST_EMPTY;
            end else begin
               addr      = tail_ff;
               tail_in   = step_down(tail_ff);
               ctl.rd_en = 1'b1;
            end
         end
         deq_pkg::FUNC_PEEK_REAR: begin
            if (empty) begin
               ctl.status = deq_pkg::ST_EMPTY;
            end else begin
               addr      = tail_ff;
               ctl.rd_en = 1'b1;
            end
         end
         deq_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               ctl.status = deq_pkg::ST_FULL;
            end else begin
               addr      = head_ff;
               head_in   = step_down(head_ff);
               ctl.wr_en = 1'b1;
            end
         end
         deq_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               ctl.status = deq_pkg::ST_EMPTY;
            end else begin
               head_in   = step_up(head_ff);
               addr      = step_up(head_ff);
               ctl.rd_en = 1'b1;
            end
         end
         deq_pkg::FUNC_PEEK_FRONT: begin
            if (empty) begin
               ctl.status = deq_pkg::ST_EMPTY;
            end else begin
               addr      = step_up(head_ff);
               ctl.rd_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Flags and count describe the pointers as they stand after the request.
      ctl.now_empty = (head_in == tail_in);
      ctl.now_full  = (step_up(tail_in) == head_in);
      cnt_wide = {1'b0, tail_in} - {1'b0, head_in};
      if (tail_in < head_in) begin
         cnt_wide = cnt_wide + (PTR_W+1)'(DEPTH);
      end
      count = cnt_wide[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule

### design/deq_fifo.sv
// Two-entry queue that decouples the front end from the back end.
// No dependencies.
module deq_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   logic [WIDTH-1:0]  entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   used_ff, used_in;
   logic              do_push, do_pop;

   assign not_empty = (used_ff != '0);
   assign full      = (used_ff == (QPTR_W+1)'(QDEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      used_in   = used_ff;
      if (do_push && !do_pop) begin
         used_in = used_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         used_in = used_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

### design/deq_back.sv
// Back end of the deque: performs the queued ring access on the RAM and
// presents the registered result in the following cycle.
// Depends on deq_pkg and deq_ram.
module deq_back #(
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  deq_pkg::deq_ctl_type       cmd_ctl,
   input  logic [$clog2(DEPTH)-1:0]   cmd_addr,
   input  logic [deq_pkg::WORD_W-1:0] cmd_wdata,
   input  logic [$clog2(DEPTH)-1:0]   cmd_count,
   output logic                       cmd_pop,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_read_value,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_now_empty,
   output logic                       rsp_now_full,
   output logic [$clog2(DEPTH)-1:0]   rsp_fill_count
);

   localparam int PTR_W = $clog2(DEPTH);

   logic                       s1_valid_ff;
   deq_pkg::deq_ctl_type       s1_ctl_ff;
   logic [PTR_W-1:0]           s1_count_ff;
   logic [deq_pkg::WORD_W-1:0] rdata;

   // The result side cannot stall, so every queued command is taken at once.
   assign cmd_pop = cmd_valid;

   deq_ram #(
      .WIDTH(deq_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(cmd_valid && cmd_ctl.wr_en),
      .rd_en(cmd_valid && cmd_ctl.rd_en),
      .addr (cmd_addr),
      .wdata(cmd_wdata),
      .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      s1_ctl_ff   <= cmd_ctl;
      s1_count_ff <= cmd_count;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_valid;
      end
   end

   assign rsp_valid      = s1_valid_ff;
   assign rsp_read_value = s1_ctl_ff.rd_en ? $signed(rdata) : 32'sd0;
   assign rsp_status     = s1_ctl_ff.status;
   assign rsp_now_empty  = s1_ctl_ff.now_empty;
   assign rsp_now_full   = s1_ctl_ff.now_full;
   assign rsp_fill_count = s1_count_ff;

endmodule

### design/deq_checker.sv
// Port-level checks for the circular deque, bound to the top level.
// Depends on deq_pkg and circular_deque.
module deq_checker #(
   parameter int DEPTH = 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic signed [31:0]       rsp_read_value,
   input logic [1:0]               rsp_status,
   input logic                     rsp_now_empty,
   input logic                     rsp_now_full,
   input logic [$clog2(DEPTH)-1:0] rsp_fill_count
);

   localparam int PTR_W = $clog2(DEPTH);

   // Every transfer yields a result after passing the command queue and the back-end registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after request transfer");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != deq_pkg::ST_OK) |-> (rsp_read_value == 32'sd0))
      else $error("error result carries a nonzero word");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_now_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_now_full == (rsp_fill_count == PTR_W'(DEPTH - 1))))
      else $error("full flag disagrees with count");

endmodule

bind circular_deque deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
